// ===== rtl/mps_pkg.sv =====
// Shared types and constants of the multi-policy scheduler.
`timescale 1ns / 1ps
package mps_pkg;
   localparam int MAX_JOBS_DEF = 16;
   localparam logic [1:0] PLACE_PEND  = 2'd0;
   localparam logic [1:0] PLACE_READY = 2'd1;
   localparam logic [1:0] PLACE_RUN   = 2'd2;
   localparam logic [2:0] MODE_FCFS = 3'd0;
   localparam logic [2:0] MODE_SJF  = 3'd1;
   localparam logic [2:0] MODE_SRTF = 3'd2;
   localparam logic [2:0] MODE_RR   = 3'd3;
   localparam logic [2:0] MODE_PRIO = 3'd4;
   localparam logic [2:0] MODE_PNP  = 3'd5;
   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_SLICE = 2'd1;
   localparam logic [1:0] REG_AGON  = 2'd2;
   localparam logic [1:0] REG_AGLIM = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ADD, ST_ARR_SCAN, ST_ARR_MOVE, ST_PRE_SCAN, ST_PRE_DO,
      ST_DISP_SCAN, ST_DISP_DO, ST_RUN, ST_AGE, ST_IDLE_SCAN, ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       start;      // latch request, clear result fields
      logic       do_add;
      logic       scan_step;  // visit the slot at the scan pointer
      logic       arr_scan;   // scan looks for arrived pending jobs
      logic       scan_clear;
      logic       arr_move;
      logic       pre_do;
      logic       disp_do;
      logic       run_do;
      logic       age_step;
      logic       out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic action;
      logic scan_last;
      logic found;
      logic running;
      logic pre_hit;
   } stat_type;
endpackage

// ===== rtl/mps_ctrl.sv =====
// Sequencer of the scheduler: walks the phases of one request.
`timescale 1ns / 1ps
module mps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  mps_pkg::stat_type stat,
   output mps_pkg::cmd_type  cmd
);
   mps_pkg::state_type state_ff, state_in;
   logic out_ff, out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mps_pkg::ST_IDLE;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_ff;
   assign req_tready = (state_ff == mps_pkg::ST_IDLE) && !out_ff;

   always_comb begin
      state_in = state_ff;
      out_in = out_ff && !rsp_tready;
      cmd = '0;
      case (state_ff)
         mps_pkg::ST_IDLE: begin
            if (req_tvalid && !out_ff) begin
               cmd.start = 1'b1;
               state_in = mps_pkg::ST_ADD;
            end
         end
         mps_pkg::ST_ADD: begin
            cmd.scan_clear = 1'b1;
            if (!stat.action) begin
               cmd.do_add = 1'b1;
               state_in = mps_pkg::ST_IDLE_SCAN;
            end else state_in = mps_pkg::ST_ARR_SCAN;
         end
         mps_pkg::ST_ARR_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.arr_scan = 1'b1;
            if (stat.scan_last) state_in = mps_pkg::ST_ARR_MOVE;
         end
         mps_pkg::ST_ARR_MOVE: begin
            cmd.scan_clear = 1'b1;
            if (stat.found) begin
               cmd.arr_move = 1'b1;
               state_in = mps_pkg::ST_ARR_SCAN;
            end else state_in = mps_pkg::ST_PRE_SCAN;
         end
         mps_pkg::ST_PRE_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) state_in = mps_pkg::ST_PRE_DO;
         end
         mps_pkg::ST_PRE_DO: begin
            cmd.scan_clear = 1'b1;
            cmd.pre_do = 1'b1;
            state_in = mps_pkg::ST_DISP_SCAN;
         end
         mps_pkg::ST_DISP_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) state_in = mps_pkg::ST_DISP_DO;
         end
         mps_pkg::ST_DISP_DO: begin
            cmd.scan_clear = 1'b1;
            cmd.disp_do = 1'b1;
            state_in = mps_pkg::ST_RUN;
         end
         mps_pkg::ST_RUN: begin
            cmd.run_do = 1'b1;
            state_in = mps_pkg::ST_AGE;
         end
         mps_pkg::ST_AGE: begin
            cmd.age_step = 1'b1;
            if (stat.scan_last) begin
               cmd.scan_clear = 1'b1;
               state_in = mps_pkg::ST_IDLE_SCAN;
            end
         end
         mps_pkg::ST_IDLE_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) state_in = mps_pkg::ST_OUT;
         end
         mps_pkg::ST_OUT: begin
            cmd.out_load = 1'b1;
            out_in = 1'b1;
            state_in = mps_pkg::ST_IDLE;
         end
         default: state_in = mps_pkg::ST_IDLE;
      endcase
   end

   // a result is never raised while one still waits
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mps_pkg::ST_OUT) |-> !out_ff)
      else $error("result overrun");
   // a request is taken only from the idle state
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == mps_pkg::ST_ADD))
      else $error("bad start");
   // the ready output stays low while a result waits
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && !req_tready)
      else $error("result dropped");
endmodule

// ===== rtl/mps_dp.sv =====
// Datapath of the scheduler: job table, scan unit and statistics.
`timescale 1ns / 1ps
module mps_dp #(
   parameter int MAX_JOBS = mps_pkg::MAX_JOBS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [48:0]       req_tdata,
   input  logic              csr_we,
   input  logic [1:0]        csr_idx,
   input  logic [15:0]       csr_wdata,
   input  mps_pkg::cmd_type  cmd,
   output mps_pkg::stat_type stat,
   output logic [87:0]       rsp_tdata
);
   localparam int SW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam logic [SW-1:0] LAST = SW'(MAX_JOBS - 1);

   // configuration
   logic [2:0]  mode_ff;
   logic [7:0]  slice_ff;
   logic        agon_ff;
   logic [15:0] aglim_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= mps_pkg::MODE_FCFS; slice_ff <= 8'd4;
         agon_ff <= 1'b0; aglim_ff <= 16'd10;
      end else if (csr_we) begin
         case (csr_idx)
            mps_pkg::REG_MODE:  mode_ff <= csr_wdata[2:0];
            mps_pkg::REG_SLICE: slice_ff <= csr_wdata[7:0];
            mps_pkg::REG_AGON:  agon_ff <= csr_wdata[0];
            mps_pkg::REG_AGLIM: aglim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // job table
   logic [MAX_JOBS-1:0] used_ff;
   logic [1:0]  place_ff [MAX_JOBS];
   logic [7:0]  ident_ff [MAX_JOBS];
   logic [15:0] arr_ff   [MAX_JOBS];
   logic [15:0] burst_ff [MAX_JOBS];
   logic [15:0] left_ff  [MAX_JOBS];
   logic [7:0]  prio_ff  [MAX_JOBS];
   logic [15:0] age_ff   [MAX_JOBS];
   logic [16:0] first_ff [MAX_JOBS];
   logic [15:0] order_ff [MAX_JOBS];

   logic [15:0] clk_ff, stamp_ff;
   logic [7:0]  sused_ff;
   logic        runv_ff;
   logic [SW-1:0] runs_ff;
   logic [48:0] req_ff;

   // scan state
   logic [SW-1:0] ptr_ff;
   logic          found_ff;
   logic [SW-1:0] pick_ff;
   logic          pre_ff;
   logic          busy_ff;
   logic          accept_ff;

   // result fields
   logic        ranv_ff, prf_ff, donev_ff;
   logic [7:0]  ranid_ff, doneid_ff;
   logic [15:0] tat_ff, wait_ff, resp_ff, tnow_ff;

   wire action = req_ff[0];
   wire [1:0] pl = place_ff[ptr_ff];
   wire cur_pend  = used_ff[ptr_ff] && pl == mps_pkg::PLACE_PEND;
   wire cur_ready = used_ff[ptr_ff] && pl == mps_pkg::PLACE_READY;
   wire [15:0] sa_cur  = stamp_ff - order_ff[ptr_ff];
   wire [15:0] sa_pick = stamp_ff - order_ff[pick_ff];

   // current slot served before picked slot in the active mode
   logic [15:0] ka, kb;
   logic keyed, prec;
   always_comb begin
      keyed = 1'b1; ka = '0; kb = '0;
      case (mode_ff)
         mps_pkg::MODE_SJF: begin ka = burst_ff[ptr_ff]; kb = burst_ff[pick_ff]; end
         mps_pkg::MODE_SRTF: begin ka = left_ff[ptr_ff]; kb = left_ff[pick_ff]; end
         mps_pkg::MODE_PRIO, mps_pkg::MODE_PNP: begin
            ka = {8'd0, prio_ff[ptr_ff]}; kb = {8'd0, prio_ff[pick_ff]};
         end
         default: keyed = 1'b0;
      endcase
      if (keyed && ka != kb) prec = ka < kb;
      else if (keyed && arr_ff[ptr_ff] != arr_ff[pick_ff])
         prec = arr_ff[ptr_ff] < arr_ff[pick_ff];
      else if (keyed && ident_ff[ptr_ff] != ident_ff[pick_ff])
         prec = ident_ff[ptr_ff] < ident_ff[pick_ff];
      else if (sa_cur != sa_pick) prec = sa_cur > sa_pick;
      else prec = ptr_ff < pick_ff;
   end

   // free slot search (priority encoder on valid bits)
   logic          free_any;
   logic [SW-1:0] free_slot;
   always_comb begin
      free_any = 1'b0; free_slot = '0;
      for (int i = MAX_JOBS - 1; i >= 0; i--)
         if (!used_ff[i]) begin free_any = 1'b1; free_slot = SW'(i); end
   end

   wire [SW-1:0] rs = runs_ff;
   wire fin = left_ff[rs] <= 16'd1;
   wire [15:0] comp = (clk_ff != 16'hFFFF) ? clk_ff + 16'd1 : 16'hFFFF;
   wire [15:0] tat = comp - arr_ff[rs];
   wire [16:0] first_d = (first_ff[rs][16]) ? {1'b0, clk_ff} : first_ff[rs];
   wire [15:0] age_inc = (age_ff[ptr_ff] != 16'hFFFF) ? age_ff[ptr_ff] + 16'd1 : 16'hFFFF;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0; clk_ff <= '0; stamp_ff <= '0; sused_ff <= '0;
         runv_ff <= 1'b0; runs_ff <= '0; ptr_ff <= '0; found_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            req_ff <= req_tdata;
            tnow_ff <= clk_ff;
            {ranv_ff, prf_ff, donev_ff} <= '0;
            ranid_ff <= '0; doneid_ff <= '0;
            tat_ff <= '0; wait_ff <= '0; resp_ff <= '0;
            accept_ff <= 1'b1;
         end
         if (cmd.scan_clear) begin
            ptr_ff <= '0; found_ff <= 1'b0; pre_ff <= 1'b0; busy_ff <= 1'b0;
         end
         if (cmd.do_add) begin
            accept_ff <= free_any;
            if (free_any) begin
               used_ff[free_slot] <= 1'b1;
               place_ff[free_slot] <= mps_pkg::PLACE_PEND;
               ident_ff[free_slot] <= req_ff[8:1];
               arr_ff[free_slot] <= req_ff[24:9];
               burst_ff[free_slot] <= req_ff[40:25];
               left_ff[free_slot] <= req_ff[40:25];
               prio_ff[free_slot] <= req_ff[48:41];
               age_ff[free_slot] <= '0;
               first_ff[free_slot] <= 17'h10000;
               order_ff[free_slot] <= stamp_ff;
               stamp_ff <= stamp_ff + 16'd1;
            end
         end
         if ((cmd.scan_step || cmd.age_step) && !cmd.scan_clear) ptr_ff <= ptr_ff + SW'(1);
         if (cmd.scan_step) begin
            if (used_ff[ptr_ff]) busy_ff <= 1'b1;
            if (cmd.arr_scan) begin
               // oldest arrived pending job
               if (action && cur_pend && arr_ff[ptr_ff] <= clk_ff &&
                   (!found_ff || sa_cur > sa_pick)) begin
                  found_ff <= 1'b1; pick_ff <= ptr_ff;
               end
            end else if (cur_ready) begin
               if ((mode_ff == mps_pkg::MODE_SRTF && left_ff[ptr_ff] < left_ff[rs]) ||
                   (mode_ff == mps_pkg::MODE_PRIO && prio_ff[ptr_ff] < prio_ff[rs]))
                  pre_ff <= 1'b1;
               if (!found_ff || prec) begin found_ff <= 1'b1; pick_ff <= ptr_ff; end
            end
         end
         if (cmd.arr_move) begin
            place_ff[pick_ff] <= mps_pkg::PLACE_READY;
            order_ff[pick_ff] <= stamp_ff;
            stamp_ff <= stamp_ff + 16'd1;
         end
         if (cmd.pre_do && runv_ff) begin
            if ((mode_ff == mps_pkg::MODE_RR && left_ff[rs] != 16'd0 &&
                 sused_ff >= slice_ff) ||
                ((mode_ff == mps_pkg::MODE_SRTF || mode_ff == mps_pkg::MODE_PRIO) &&
                 pre_ff)) begin
               place_ff[rs] <= mps_pkg::PLACE_READY;
               order_ff[rs] <= stamp_ff;
               stamp_ff <= stamp_ff + 16'd1;
               runv_ff <= 1'b0; sused_ff <= '0; prf_ff <= 1'b1;
            end
         end
         if (cmd.disp_do && !runv_ff && found_ff) begin
            place_ff[pick_ff] <= mps_pkg::PLACE_RUN;
            runs_ff <= pick_ff; runv_ff <= 1'b1; sused_ff <= '0;
            if (first_ff[pick_ff][16]) first_ff[pick_ff] <= {1'b0, clk_ff};
         end
         if (cmd.run_do) begin
            if (runv_ff) begin
               ranv_ff <= 1'b1; ranid_ff <= ident_ff[rs];
               left_ff[rs] <= (left_ff[rs] != 16'd0) ? left_ff[rs] - 16'd1 : 16'd0;
               sused_ff <= fin ? 8'd0 :
                           ((sused_ff != 8'hFF) ? sused_ff + 8'd1 : sused_ff);
               if (fin) begin
                  donev_ff <= 1'b1; doneid_ff <= ident_ff[rs];
                  tat_ff <= tat;
                  wait_ff <= (tat > burst_ff[rs]) ? tat - burst_ff[rs] : 16'd0;
                  resp_ff <= first_d[15:0] - arr_ff[rs];
                  used_ff[rs] <= 1'b0; runv_ff <= 1'b0;
               end
            end
            if (clk_ff != 16'hFFFF) clk_ff <= clk_ff + 16'd1;
         end
         if (cmd.age_step && agon_ff && cur_ready) begin
            if (age_inc >= aglim_ff) begin
               age_ff[ptr_ff] <= '0;
               if (prio_ff[ptr_ff] != 8'd0) prio_ff[ptr_ff] <= prio_ff[ptr_ff] - 8'd1;
            end else age_ff[ptr_ff] <= age_inc;
         end
      end
   end

   assign stat.action = action;
   assign stat.scan_last = ptr_ff == LAST;
   assign stat.found = found_ff;
   assign stat.running = runv_ff;
   assign stat.pre_hit = pre_ff;

   // result register
   logic [87:0] out_ff;
   always_ff @(posedge clock) begin
      if (cmd.out_load)
         out_ff <= {3'b0, tnow_ff, !busy_ff, resp_ff, wait_ff, tat_ff, doneid_ff,
                    donev_ff, prf_ff, ranid_ff, ranv_ff, accept_ff};
   end
   assign rsp_tdata = out_ff;

   // a finished job is never the one still marked running
   a_fin_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.run_do && runv_ff && fin |=> !runv_ff)
      else $error("finished job still running");
   // the running slot is always a used slot
   a_run_used: assert property (@(posedge clock) disable iff (reset)
      runv_ff |-> used_ff[runs_ff])
      else $error("running slot unused");
   // the tick counter moves only on a run step
   a_clk: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.run_do) && !$past(reset) |-> $stable(clk_ff))
      else $error("clock moved");
endmodule

// ===== rtl/multi_policy_cpu_scheduler.sv =====
// Top level of the multi-policy job scheduler.
// The time from request accept to result valid is set by the serial slot scans: an add
// scans the table once; a tick scans it once per arrival plus once more for each of the
// arrival search, preemption, dispatch, aging and idle check. Requests are handled one
// at a time; the next is taken only after the result has left.
// Synchronous active-high reset clears the table valid bits, the clock, the run state and
// sets the configuration registers to their defaults; no clearing pass is needed.
`timescale 1ns / 1ps
module multi_policy_cpu_scheduler #(
   parameter int MAX_JOBS = mps_pkg::MAX_JOBS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action, job_id, arrive_at, burst_len, prio_value
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // accepted, ran_valid, ran_id, preempt_flag, done_valid, done_id,
   // turnaround, wait_total, response, all_idle, time_now
   output logic [87:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_idx,
   input  logic [15:0] csr_wdata
);
   mps_pkg::cmd_type  cmd;
   mps_pkg::stat_type stat;

   mps_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .stat(stat), .cmd(cmd)
   );

   mps_dp #(.MAX_JOBS(MAX_JOBS)) u_dp (
      .clock(clock), .reset(reset), .req_tdata(req_tdata[48:0]), .csr_we(csr_we),
      .csr_idx(csr_idx), .csr_wdata(csr_wdata), .cmd(cmd), .stat(stat),
      .rsp_tdata(rsp_tdata)
   );
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the multi-policy job scheduler.
`timescale 1ns / 1ps
module testbench;
   localparam int SLOTS = mps_pkg::MAX_JOBS_DEF;
   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef struct {
      logic        accepted;
      logic        ran_valid;
      logic [7:0]  ran_id;
      logic        preempt;
      logic        done_valid;
      logic [7:0]  done_id;
      logic [15:0] turnaround;
      logic [15:0] wait_total;
      logic [15:0] response;
      logic        all_idle;
      logic [15:0] time_now;
   } sched_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_idx = '0;
   logic [15:0] csr_wdata = '0;

   multi_policy_cpu_scheduler dut (.*);

   always #6 clock = ~clock;

   // scheduler state mirrored by the predictor
   logic [2:0]  cfg_mode;
   logic [7:0]  cfg_slice;
   logic        cfg_agon;
   logic [15:0] cfg_aglim;
   logic [15:0] now_tick;
   logic [7:0]  slice_cnt;
   logic        cpu_busy;
   int          cpu_slot;
   logic [15:0] order_stamp;
   logic        jt_used  [SLOTS];
   logic [1:0]  jt_place [SLOTS];
   logic [7:0]  jt_id    [SLOTS];
   logic [15:0] jt_arr   [SLOTS];
   logic [15:0] jt_burst [SLOTS];
   logic [15:0] jt_left  [SLOTS];
   logic [7:0]  jt_prio  [SLOTS];
   logic [15:0] jt_age   [SLOTS];
   logic [16:0] jt_first [SLOTS];
   logic [15:0] jt_order [SLOTS];

   sched_result_type pending_results[$];
   int errors = 0;
   int hold_cycles = 0;
   int burst_left = 0;

   function automatic logic [15:0] stamp_dist(int s);
      return order_stamp - jt_order[s];
   endfunction

   function automatic void take_stamp(int s);
      jt_order[s] = order_stamp;
      order_stamp = order_stamp + 16'd1;
   endfunction

   // true if slot a is served before slot b under the current mode
   function automatic bit serves_first(int a, int b);
      int unsigned ka, kb;
      bit keyed;
      keyed = 1'b1;
      ka = 0;
      kb = 0;
      case (cfg_mode)
         mps_pkg::MODE_SJF: begin
            ka = 32'(jt_burst[a]); kb = 32'(jt_burst[b]);
         end
         mps_pkg::MODE_SRTF: begin
            ka = 32'(jt_left[a]); kb = 32'(jt_left[b]);
         end
         mps_pkg::MODE_PRIO, mps_pkg::MODE_PNP: begin
            ka = 32'(jt_prio[a]); kb = 32'(jt_prio[b]);
         end
         default: keyed = 1'b0;
      endcase
      if (keyed) begin
         if (ka != kb) return ka < kb;
         if (jt_arr[a] != jt_arr[b]) return jt_arr[a] < jt_arr[b];
         if (jt_id[a] != jt_id[b]) return jt_id[a] < jt_id[b];
      end
      if (stamp_dist(a) != stamp_dist(b)) return stamp_dist(a) > stamp_dist(b);
      return a < b;
   endfunction

   function automatic void schedule_reset();
      cfg_mode = mps_pkg::MODE_FCFS; cfg_slice = 8'd4; cfg_agon = 1'b0; cfg_aglim = 16'd10;
      now_tick = '0; slice_cnt = '0; cpu_busy = 1'b0; cpu_slot = 0; order_stamp = '0;
      for (int s = 0; s < SLOTS; s++) jt_used[s] = 1'b0;
   endfunction

   // expected result of one request; updates the mirrored state
   function automatic sched_result_type schedule_step(logic act, logic [7:0] id,
         logic [15:0] arr, logic [15:0] burst, logic [7:0] prio);
      sched_result_type r;
      int pick;
      bit pre, fin;
      logic [15:0] comp, tat;
      r = '{default: '0};
      r.time_now = now_tick;
      if (act == ACT_ADD) begin
         for (int s = 0; s < SLOTS; s++) begin
            if (!jt_used[s]) begin
               jt_used[s] = 1'b1; jt_place[s] = mps_pkg::PLACE_PEND; jt_id[s] = id;
               jt_arr[s] = arr; jt_burst[s] = burst; jt_left[s] = burst;
               jt_prio[s] = prio; jt_age[s] = '0; jt_first[s] = 17'h10000;
               take_stamp(s);
               r.accepted = 1'b1;
               break;
            end
         end
      end else begin
         r.accepted = 1'b1;
         // arrivals, oldest add first
         for (int n = 0; n < SLOTS; n++) begin
            pick = -1;
            for (int s = 0; s < SLOTS; s++) begin
               if (!jt_used[s] || jt_place[s] != mps_pkg::PLACE_PEND ||
                   jt_arr[s] > now_tick)
                  continue;
               if (pick < 0 || stamp_dist(s) > stamp_dist(pick)) pick = s;
            end
            if (pick < 0) break;
            jt_place[pick] = mps_pkg::PLACE_READY;
            take_stamp(pick);
         end
         // preemption
         if (cpu_busy) begin
            pre = 1'b0;
            if (cfg_mode == mps_pkg::MODE_RR) begin
               pre = jt_left[cpu_slot] > 0 && slice_cnt >= cfg_slice;
            end else if (cfg_mode == mps_pkg::MODE_SRTF || cfg_mode == mps_pkg::MODE_PRIO) begin
               for (int s = 0; s < SLOTS; s++) begin
                  if (!jt_used[s] || jt_place[s] != mps_pkg::PLACE_READY) continue;
                  if (cfg_mode == mps_pkg::MODE_SRTF ? jt_left[s] < jt_left[cpu_slot]
                                                     : jt_prio[s] < jt_prio[cpu_slot])
                     pre = 1'b1;
               end
            end
            if (pre) begin
               jt_place[cpu_slot] = mps_pkg::PLACE_READY;
               take_stamp(cpu_slot);
               cpu_busy = 1'b0;
               slice_cnt = '0;
               r.preempt = 1'b1;
            end
         end
         // dispatch
         if (!cpu_busy) begin
            pick = -1;
            for (int s = 0; s < SLOTS; s++) begin
               if (!jt_used[s] || jt_place[s] != mps_pkg::PLACE_READY) continue;
               if (pick < 0 || serves_first(s, pick)) pick = s;
            end
            if (pick >= 0) begin
               jt_place[pick] = mps_pkg::PLACE_RUN;
               cpu_slot = pick;
               cpu_busy = 1'b1;
               slice_cnt = '0;
               if (jt_first[pick][16]) jt_first[pick] = {1'b0, now_tick};
            end
         end
         // run one unit
         if (cpu_busy) begin
            fin = jt_left[cpu_slot] <= 1;
            r.ran_valid = 1'b1;
            r.ran_id = jt_id[cpu_slot];
            if (jt_left[cpu_slot] > 0) jt_left[cpu_slot]--;
            if (slice_cnt < 8'hFF) slice_cnt++;
            if (fin) begin
               comp = now_tick < 16'hFFFF ? now_tick + 16'd1 : 16'hFFFF;
               tat = comp - jt_arr[cpu_slot];
               r.done_valid = 1'b1;
               r.done_id = jt_id[cpu_slot];
               r.turnaround = tat;
               r.wait_total = tat > jt_burst[cpu_slot] ? tat - jt_burst[cpu_slot] : '0;
               r.response = jt_first[cpu_slot][15:0] - jt_arr[cpu_slot];
               jt_used[cpu_slot] = 1'b0;
               cpu_busy = 1'b0;
               slice_cnt = '0;
            end
         end
         // aging
         if (cfg_agon) begin
            for (int s = 0; s < SLOTS; s++) begin
               if (!jt_used[s] || jt_place[s] != mps_pkg::PLACE_READY) continue;
               if (jt_age[s] < 16'hFFFF) jt_age[s]++;
               if (jt_age[s] >= cfg_aglim) begin
                  if (jt_prio[s] > 0) jt_prio[s]--;
                  jt_age[s] = '0;
               end
            end
         end
         if (now_tick < 16'hFFFF) now_tick++;
      end
      r.all_idle = 1'b1;
      for (int s = 0; s < SLOTS; s++) if (jt_used[s]) r.all_idle = 1'b0;
      return r;
   endfunction

   // send one request, with random gaps between bursts
   task automatic send_request(logic act, logic [7:0] id, logic [15:0] arr,
         logic [15:0] burst, logic [7:0] prio);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, prio, burst, arr, id, act};
      do @(posedge clock); while (!req_tready);
      pending_results.insert(pending_results.size(),
                             schedule_step(act, id, arr, burst, prio));
   endtask

   // stop sending and wait until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         mps_pkg::REG_MODE:  cfg_mode = value[2:0];
         mps_pkg::REG_SLICE: cfg_slice = value[7:0];
         mps_pkg::REG_AGON:  cfg_agon = value[0];
         default:            cfg_aglim = value;
      endcase
   endtask

   task automatic tick();
      send_request(ACT_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
   endtask

   // duplicate ids, zero burst, late arrival under FCFS
   task automatic test_fcfs_basics();
      send_request(ACT_ADD, 8'd5, 16'd0, 16'd2, 8'd3);
      send_request(ACT_ADD, 8'd5, 16'd0, 16'd0, 8'd1);
      send_request(ACT_ADD, 8'd9, 16'd2, 16'd1, 8'd0);
      repeat (6) tick();
      drain();
   endtask

   // random workload under one register setting
   task automatic test_policy(logic [2:0] mode, logic [7:0] slice, logic agon,
         logic [15:0] aglim, int count, bit hold_off, bit mid_pause);
      write_reg(mps_pkg::REG_MODE, {13'd0, mode});
      write_reg(mps_pkg::REG_SLICE, {8'd0, slice});
      write_reg(mps_pkg::REG_AGON, {15'd0, agon});
      write_reg(mps_pkg::REG_AGLIM, aglim);
      for (int i = 0; i < count; i++) begin
         if (hold_off && i == 10) hold_cycles = 400;
         if (mid_pause && i == count / 2) drain();
         if ($urandom_range(0, 99) < 22)
            send_request(ACT_ADD, 8'($urandom_range(0, 255)),
                         now_tick + 16'($urandom_range(0, 8)),
                         16'($urandom_range(0, 8)), 8'($urandom_range(0, 255)));
         else
            tick();
      end
      drain();
   endtask

   // extreme field values and a full table
   task automatic test_extremes();
      write_reg(mps_pkg::REG_MODE, {13'd0, mps_pkg::MODE_SRTF});
      send_request(ACT_ADD, 8'd0, 16'd0, 16'hFFFF, 8'd0);
      send_request(ACT_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      for (int i = 0; i < 15; i++)
         send_request(ACT_ADD, 8'hFF, 16'hFFFF, 16'h8000, 8'hFF);
      repeat (4) tick();
      drain();
   endtask

   // result checker
   task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      sched_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
         end else begin
            e = pending_results.pop_front();
            check_field("accepted", 16'(e.accepted), 16'(rsp_tdata[0]));
            check_field("ran_valid", 16'(e.ran_valid), 16'(rsp_tdata[1]));
            check_field("ran_id", 16'(e.ran_id), 16'(rsp_tdata[9:2]));
            check_field("preempt_flag", 16'(e.preempt), 16'(rsp_tdata[10]));
            check_field("done_valid", 16'(e.done_valid), 16'(rsp_tdata[11]));
            check_field("done_id", 16'(e.done_id), 16'(rsp_tdata[19:12]));
            check_field("turnaround", e.turnaround, rsp_tdata[35:20]);
            check_field("wait_total", e.wait_total, rsp_tdata[51:36]);
            check_field("response", e.response, rsp_tdata[67:52]);
            check_field("all_idle", 16'(e.all_idle), 16'(rsp_tdata[68]));
            check_field("time_now", e.time_now, rsp_tdata[84:69]);
         end
      end
   end

   // receiver stall pattern, with a long hold-off on demand
   int pat_left = 0;
   int stall_pct = 0;
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         if (pat_left == 0) begin
            pat_left = $urandom_range(20, 200);
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 25;
               default: stall_pct = 60;
            endcase
         end
         pat_left--;
         rsp_tready <= $urandom_range(0, 99) >= stall_pct;
      end
   end

   initial begin
      #30_000_000;
      $display("testbench: errors");
      $finish;
   end

   initial begin
      schedule_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fcfs_basics();
      test_policy(mps_pkg::MODE_SJF,  8'd4,   1'b0, 16'd10,    85, 1'b0, 1'b0);
      test_policy(mps_pkg::MODE_SRTF, 8'd4,   1'b1, 16'd3,     85, 1'b0, 1'b0);
      test_policy(mps_pkg::MODE_RR,   8'd1,   1'b0, 16'd10,    85, 1'b1, 1'b0);
      test_policy(mps_pkg::MODE_RR,   8'd0,   1'b1, 16'd0,     85, 1'b0, 1'b0);
      test_policy(mps_pkg::MODE_PRIO, 8'd4,   1'b1, 16'd1,     85, 1'b0, 1'b0);
      test_policy(mps_pkg::MODE_PNP,  8'd255, 1'b1, 16'hFFFF,  85, 1'b0, 1'b1);
      test_policy(3'd6,               8'd2,   1'b0, 16'd5,     85, 1'b0, 1'b0);
      test_policy(3'd7,               8'd3,   1'b1, 16'd2,     85, 1'b0, 1'b0);
      test_policy(mps_pkg::MODE_RR,   8'd255, 1'b1, 16'd1,     85, 1'b0, 1'b0);
      test_policy(mps_pkg::MODE_FCFS, 8'd7,   1'b1, 16'd4,     85, 1'b0, 1'b0);
      test_policy(mps_pkg::MODE_PRIO, 8'd2,   1'b1, 16'd0,     85, 1'b0, 1'b0);
      test_policy(mps_pkg::MODE_SRTF, 8'd1,   1'b0, 16'hFFFF,  85, 1'b0, 1'b0);
      test_extremes();
      repeat (400) @(posedge clock);
      if (errors == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/mps_pkg.sv
rtl/mps_ctrl.sv
rtl/mps_dp.sv
rtl/multi_policy_cpu_scheduler.sv
dv/testbench.sv
